>>> sv/playfair_digraph_encrypt_core_defines.svh
// Assertion macros for the Playfair digraph encryptor checker
`ifndef PLAYFAIR_DIGRAPH_ENCRYPT_CORE_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_ENCRYPT_CORE_DEFINES_SVH

// Consequent in the cycle after the antecedent, ignored while in reset
`define PFENC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfenc check failed");

// Consequent in the cycle after the antecedent, checked through reset as well
`define PFENC_ASSERT_RESET(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pfenc check failed");

`endif

>>> sv/pfenc_pkg.sv
// Shared types and constants of the Playfair digraph encryptor
package pfenc_pkg;

  localparam int unsigned LETTER_W = 5;
  localparam int unsigned SIDE     = 5;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CFG_W    = 50;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [LETTER_W-1:0] FILLER_RESET = 5'd22;
  localparam logic [LETTER_W-1:0] PLAIN_Z      = 5'd25;
  localparam logic [LETTER_W-1:0] PLAIN_J      = 5'd9;
  localparam logic [LETTER_W-1:0] CODE_Z       = 5'd24;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_0_1  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_2_3  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_4     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILLER    = 2'd3;

  typedef logic [LETTER_W-1:0] letter_t;
  typedef logic [IDX_W-1:0]    idx_t;

  // square[row][col] holds a cell's letter code
  typedef logic [SIDE-1:0][SIDE-1:0][LETTER_W-1:0] square_t;

  // One pair of folded letters waiting for encryption
  typedef struct packed {
    letter_t a;
    letter_t b;
    logic    last;
  } pair_t;

  // Map a plain letter a..z onto the 25-letter alphabet, j joining i
  function automatic letter_t fold_plain(input letter_t p);
    letter_t q;
    q = (p > PLAIN_Z) ? PLAIN_Z : p;
    if (q >= PLAIN_J) begin
      q = q - letter_t'(1);
    end
    return q;
  endfunction

  function automatic letter_t fold_filler(input letter_t f);
    return (f > CODE_Z) ? CODE_Z : f;
  endfunction

endpackage

>>> sv/pfenc_front.sv
// Front end: takes plain letters, pairs them and issues pair commands
module pfenc_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pfenc_pkg::letter_t        filler_letter,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [4:0]                in_plain_letter,
  input  logic                      in_end_of_message,
  input  logic                      q_full,
  output logic                      push,
  output pfenc_pkg::pair_t          push_pair
);

  pfenc_pkg::letter_t held_r, held_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic               extra_valid_r, extra_valid_nxt;
  pfenc_pkg::pair_t   extra_r, extra_nxt;

  pfenc_pkg::letter_t letter;
  pfenc_pkg::letter_t fill;
  logic               accept;
  logic               new_push;
  pfenc_pkg::pair_t   new_pair;

  assign in_stall = extra_valid_r | q_full;
  assign accept   = in_valid & ~in_stall;
  assign letter   = pfenc_pkg::fold_plain(in_plain_letter);
  assign fill     = pfenc_pkg::fold_filler(filler_letter);

  always_comb begin
    held_nxt        = held_r;
    held_valid_nxt  = held_valid_r;
    extra_valid_nxt = extra_valid_r;
    extra_nxt       = extra_r;
    new_push        = 1'b0;
    new_pair        = '{a: letter, b: fill, last: 1'b1};

    // drain the second pair of a doubled letter at end of message
    if (extra_valid_r && !q_full) begin
      extra_valid_nxt = 1'b0;
    end

    if (accept) begin
      if (!held_valid_r) begin
        if (in_end_of_message) begin
          new_push = 1'b1;
        end else begin
          held_nxt       = letter;
          held_valid_nxt = 1'b1;
        end
      end else if (held_r != letter) begin
        new_push       = 1'b1;
        new_pair       = '{a: held_r, b: letter, last: 1'b1};
        held_valid_nxt = 1'b0;
      end else begin
        new_push = 1'b1;
        new_pair = '{a: held_r, b: fill, last: ~in_end_of_message};
        held_nxt = letter;
        if (in_end_of_message) begin
          held_valid_nxt  = 1'b0;
          extra_valid_nxt = 1'b1;
          extra_nxt       = '{a: letter, b: fill, last: 1'b1};
        end
      end
    end
  end

  assign push      = new_push | (extra_valid_r & ~q_full);
  assign push_pair = extra_valid_r ? extra_r : new_pair;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r        <= '0;
      held_valid_r  <= 1'b0;
      extra_valid_r <= 1'b0;
    end else begin
      held_r        <= held_nxt;
      held_valid_r  <= held_valid_nxt;
      extra_valid_r <= extra_valid_nxt;
    end
    extra_r <= extra_nxt;
  end

endmodule

>>> sv/pfenc_queue.sv
// Short pair queue between the front and back ends
module pfenc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  pfenc_pkg::pair_t push_pair,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output pfenc_pkg::pair_t head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  pfenc_pkg::pair_t  mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_pair;
    end
  end

endmodule

>>> sv/pfenc_back.sv
// Back end: locates a pair in the square, applies the rules, emits two letters
module pfenc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  pfenc_pkg::square_t     square,
  input  logic                   q_empty,
  input  pfenc_pkg::pair_t       q_head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [4:0]             out_cipher_letter,
  output logic                   out_last_of_run
);

  localparam pfenc_pkg::idx_t SIDE_LAST = pfenc_pkg::idx_t'(pfenc_pkg::SIDE - 1);

  // lookup stage
  logic            lk_valid_r, lk_valid_nxt;
  pfenc_pkg::idx_t lk_ra_r, lk_ca_r, lk_rb_r, lk_cb_r;
  logic            lk_last_r;

  // emit stage
  logic               pr_valid_r, pr_valid_nxt;
  logic               pr_phase_r, pr_phase_nxt;
  pfenc_pkg::letter_t pr_ea_r, pr_eb_r;
  logic               pr_last_r;

  pfenc_pkg::idx_t ra, ca, rb, cb;
  logic            fa, fb;
  pfenc_pkg::idx_t oar, oac, obr, obc;
  logic            out_take, pr_free, lk_free;

  // first matching cell wins; an absent letter sits at row 0, col 0
  always_comb begin
    ra = '0; ca = '0; rb = '0; cb = '0;
    fa = 1'b0; fb = 1'b0;
    for (int r = 0; r < pfenc_pkg::SIDE; r++) begin
      for (int c = 0; c < pfenc_pkg::SIDE; c++) begin
        if (!fa && square[r][c] == q_head.a) begin
          ra = pfenc_pkg::idx_t'(r);
          ca = pfenc_pkg::idx_t'(c);
          fa = 1'b1;
        end
        if (!fb && square[r][c] == q_head.b) begin
          rb = pfenc_pkg::idx_t'(r);
          cb = pfenc_pkg::idx_t'(c);
          fb = 1'b1;
        end
      end
    end
  end

  // Playfair rules on the located cells
  always_comb begin
    if (lk_ra_r == lk_rb_r) begin
      oar = lk_ra_r;
      obr = lk_rb_r;
      oac = (lk_ca_r == SIDE_LAST) ? '0 : lk_ca_r + pfenc_pkg::idx_t'(1);
      obc = (lk_cb_r == SIDE_LAST) ? '0 : lk_cb_r + pfenc_pkg::idx_t'(1);
    end else if (lk_ca_r == lk_cb_r) begin
      oac = lk_ca_r;
      obc = lk_cb_r;
      oar = (lk_ra_r == SIDE_LAST) ? '0 : lk_ra_r + pfenc_pkg::idx_t'(1);
      obr = (lk_rb_r == SIDE_LAST) ? '0 : lk_rb_r + pfenc_pkg::idx_t'(1);
    end else begin
      oar = lk_ra_r;
      oac = lk_cb_r;
      obr = lk_rb_r;
      obc = lk_ca_r;
    end
  end

  assign out_valid         = pr_valid_r;
  assign out_cipher_letter = pr_phase_r ? pr_eb_r : pr_ea_r;
  assign out_last_of_run   = pr_phase_r & pr_last_r;

  assign out_take = pr_valid_r & ~out_stall;
  assign pr_free  = ~pr_valid_r | (pr_phase_r & out_take);
  assign lk_free  = ~lk_valid_r | pr_free;
  assign pop      = lk_free & ~q_empty;

  always_comb begin
    lk_valid_nxt = lk_valid_r;
    pr_valid_nxt = pr_valid_r;
    pr_phase_nxt = pr_phase_r;
    if (lk_free) begin
      lk_valid_nxt = ~q_empty;
    end
    if (pr_free) begin
      pr_valid_nxt = lk_valid_r;
      pr_phase_nxt = 1'b0;
    end else if (out_take) begin
      pr_phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_valid_r <= 1'b0;
      pr_valid_r <= 1'b0;
      pr_phase_r <= 1'b0;
    end else begin
      lk_valid_r <= lk_valid_nxt;
      pr_valid_r <= pr_valid_nxt;
      pr_phase_r <= pr_phase_nxt;
    end
    if (pop) begin
      lk_ra_r   <= ra;
      lk_ca_r   <= ca;
      lk_rb_r   <= rb;
      lk_cb_r   <= cb;
      lk_last_r <= q_head.last;
    end
    if (pr_free && lk_valid_r) begin
      pr_ea_r   <= square[oar][oac];
      pr_eb_r   <= square[obr][obc];
      pr_last_r <= lk_last_r;
    end
  end

endmodule

>>> sv/playfair_digraph_encrypt_core.sv
// An accepted item that completes a pair is written to the pair queue, then registered in the
// lookup stage and the emit stage, which presents the first cipher letter and then the second.
// Throughput is set by the single output port: one letter per cycle while out_stall is low.
// An input item is taken every cycle while the 4-entry pair queue has room; a doubled letter
// at end of message needs two queue slots and holds the input until its second pair is pushed.
// Reset (synchronous, active low) clears the held letter, the queue and both back-end stages;
// the key square resets to all zero and the filler to x.
module playfair_digraph_encrypt_core #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [pfenc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfenc_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [4:0]                           in_plain_letter,
  input  logic                                 in_end_of_message,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [4:0]                           out_cipher_letter,
  output logic                                 out_last_of_run
);

  logic [49:0]        sq01_r;
  logic [49:0]        sq23_r;
  logic [24:0]        sq4_r;
  pfenc_pkg::letter_t filler_r;

  pfenc_pkg::square_t square;
  logic               q_full, q_empty, push, pop;
  pfenc_pkg::pair_t   push_pair, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq01_r   <= '0;
      sq23_r   <= '0;
      sq4_r    <= '0;
      filler_r <= pfenc_pkg::FILLER_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        pfenc_pkg::CFG_ROWS_0_1: sq01_r   <= cfg_wr_data[49:0];
        pfenc_pkg::CFG_ROWS_2_3: sq23_r   <= cfg_wr_data[49:0];
        pfenc_pkg::CFG_ROW_4:    sq4_r    <= cfg_wr_data[24:0];
        pfenc_pkg::CFG_FILLER:   filler_r <= cfg_wr_data[4:0];
        default: ;
      endcase
    end
  end

  // unpack the register words into rows and columns
  always_comb begin
    for (int r = 0; r < pfenc_pkg::SIDE; r++) begin
      for (int c = 0; c < pfenc_pkg::SIDE; c++) begin
        if (r < 2) begin
          square[r][c] = sq01_r[pfenc_pkg::LETTER_W*(r*pfenc_pkg::SIDE+c) +: pfenc_pkg::LETTER_W];
        end else if (r < 4) begin
          square[r][c] =
            sq23_r[pfenc_pkg::LETTER_W*((r-2)*pfenc_pkg::SIDE+c) +: pfenc_pkg::LETTER_W];
        end else begin
          square[r][c] = sq4_r[pfenc_pkg::LETTER_W*c +: pfenc_pkg::LETTER_W];
        end
      end
    end
  end

  pfenc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .filler_letter     (filler_r),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_plain_letter   (in_plain_letter),
    .in_end_of_message (in_end_of_message),
    .q_full            (q_full),
    .push              (push),
    .push_pair         (push_pair)
  );

  pfenc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_pair (push_pair),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (q_head)
  );

  pfenc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .square            (square),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cipher_letter (out_cipher_letter),
    .out_last_of_run   (out_last_of_run)
  );

endmodule

>>> sv/pfenc_checker.sv
// Port-level checks for the Playfair digraph encryptor, bound to the top level
`include "playfair_digraph_encrypt_core_defines.svh"

module pfenc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [4:0]  in_plain_letter,
  input logic        in_end_of_message,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  out_cipher_letter,
  input logic        out_last_of_run
);

  logic [5:0] in_word;
  logic [5:0] out_word;

  assign in_word  = {in_plain_letter, in_end_of_message};
  assign out_word = {out_cipher_letter, out_last_of_run};

  // a stalled item holds on either channel
  `PFENC_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(in_word))
  `PFENC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  // reset empties the back end and frees the input
  `PFENC_ASSERT_RESET(a_rst_out_idle, !rst_n, !out_valid)
  `PFENC_ASSERT_RESET(a_rst_in_free, !rst_n, !in_stall)

  // a run always ends on the second letter of a pair, so no run ends twice in a row
  `PFENC_ASSERT_NEXT(a_last_not_twice, out_valid && !out_stall && out_last_of_run, !(out_valid && out_last_of_run))

endmodule

bind playfair_digraph_encrypt_core pfenc_checker u_pfenc_checker (.*);
